// ===== rtl/annexb_access_unit_splitter_macros.svh =====
// Assertion macros shared by the access unit splitter RTL.
`ifndef ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH
`define ANNEXB_ACCESS_UNIT_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define AAUS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define AAUS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aaus_pkg.sv =====
// Shared types and constants of the access unit splitter.
package aaus_pkg;

  localparam int BYTE_W     = 8;
  localparam int NAL_TYPE_W = 5;
  localparam int MASK_W     = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int LOOKAHEAD_DEPTH_DEF = 6;

  localparam logic [MASK_W-1:0]     ATTACH_MASK_RESET = 32'h0000_03C0;
  localparam logic [NAL_TYPE_W-1:0] KEY_TYPE_RESET    = 5'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACH_MASK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TYPE    = 1'b1;

  // Start code bytes still to pass after the first one: 4-byte and 3-byte codes.
  localparam logic [1:0] ZR_LONG  = 2'd3;
  localparam logic [1:0] ZR_SHORT = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              keyframe;
    logic              first;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } res_t;

  typedef struct packed {
    logic full;
    logic synced;
  } status_t;

endpackage

// ===== rtl/aaus_window.sv =====
// Lookahead window, start code detection and access unit state.
module aaus_window #(
  parameter int DEPTH = 6
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [aaus_pkg::BYTE_W-1:0]            stream_byte,
  input  logic                                   restart,
  input  logic [aaus_pkg::MASK_W-1:0]            attach_mask,
  input  logic [aaus_pkg::NAL_TYPE_W-1:0]        key_type,
  output aaus_pkg::res_t                         res,
  output aaus_pkg::status_t                      st
);
  import aaus_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] win [DEPTH];
  logic [CW-1:0]     count;
  logic [1:0]        zero_run;
  logic              await_header;
  logic              synced;
  logic              first_nal_pending;
  logic              current_keyframe;

  logic [1:0] zero_run_next;
  logic       await_header_next;
  logic       synced_next;
  logic       first_nal_pending_next;
  logic       current_keyframe_next;

  logic                  full;
  logic                  sc0_long, sc0_short, sc0;
  logic                  sc1_long, sc1_short, sc1;
  logic [NAL_TYPE_W-1:0] hdr0_type, hdr1_type;
  logic                  emit, open_unit, last;
  logic [1:0]            zr;
  logic                  ah;

  assign full = (count == CW'(DEPTH));

  // Start code at the head of the window and one byte further on.
  assign sc0_long  = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h00) &&
                     (win[3] == 8'h01);
  assign sc0_short = !sc0_long && (win[0] == 8'h00) && (win[1] == 8'h00) &&
                     (win[2] == 8'h01);
  assign sc0       = sc0_long || sc0_short;
  assign hdr0_type = sc0_long ? win[4][NAL_TYPE_W-1:0] : win[3][NAL_TYPE_W-1:0];

  assign sc1_long  = (win[1] == 8'h00) && (win[2] == 8'h00) && (win[3] == 8'h00) &&
                     (win[4] == 8'h01);
  assign sc1_short = !sc1_long && (win[1] == 8'h00) && (win[2] == 8'h00) &&
                     (win[3] == 8'h01);
  assign sc1       = sc1_long || sc1_short;
  assign hdr1_type = sc1_long ? win[5][NAL_TYPE_W-1:0] : win[4][NAL_TYPE_W-1:0];

  assign emit      = accept && full && !restart && (synced || sc0);
  assign open_unit = first_nal_pending && sc0;

  always_comb begin
    zero_run_next          = zero_run;
    await_header_next      = await_header;
    synced_next            = synced;
    first_nal_pending_next = first_nal_pending;
    current_keyframe_next  = current_keyframe;
    last                   = 1'b0;
    zr                     = zero_run;
    ah                     = await_header;
    if (emit) begin
      if (open_unit) begin
        zr                     = sc0_long ? ZR_LONG : ZR_SHORT;
        ah                     = 1'b1;
        current_keyframe_next  = (hdr0_type == key_type);
        first_nal_pending_next = 1'b0;
      end
      synced_next       = 1'b1;
      zero_run_next     = zr;
      await_header_next = ah;
      if (zr != 2'd0) begin
        zero_run_next = zr - 2'd1;
      end else if (ah) begin
        await_header_next = 1'b0;
      end else if (sc1) begin
        if (attach_mask[hdr1_type]) begin
          zero_run_next     = sc1_long ? ZR_LONG : ZR_SHORT;
          await_header_next = 1'b1;
        end else begin
          last                   = 1'b1;
          first_nal_pending_next = 1'b1;
        end
      end
    end
  end

  assign res.valid         = emit;
  assign res.item.data     = win[0];
  assign res.item.last     = last;
  assign res.item.keyframe = current_keyframe_next;
  assign res.item.first    = emit && open_unit;

  assign st.full   = full;
  assign st.synced = synced;

  // The window shifts on each accepted byte; after DEPTH items the oldest byte sits at the head.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[DEPTH-1] <= stream_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count             <= '0;
      zero_run          <= '0;
      await_header      <= 1'b0;
      synced            <= 1'b0;
      first_nal_pending <= 1'b1;
      current_keyframe  <= 1'b0;
    end else if (accept && restart) begin
      count             <= CW'(1);
      zero_run          <= '0;
      await_header      <= 1'b0;
      synced            <= 1'b0;
      first_nal_pending <= 1'b1;
      current_keyframe  <= 1'b0;
    end else if (accept) begin
      if (!full) begin
        count <= count + CW'(1);
      end
      zero_run          <= zero_run_next;
      await_header      <= await_header_next;
      synced            <= synced_next;
      first_nal_pending <= first_nal_pending_next;
      current_keyframe  <= current_keyframe_next;
    end
  end

endmodule

// ===== rtl/aaus_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry.
module aaus_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  aaus_pkg::res_t  res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output aaus_pkg::item_t out_item
);
  import aaus_pkg::*;

  logic  v0, v1;
  item_t e0, e1;
  logic  pop;
  logic  a0;

  assign pop = v0 && !out_stall;
  // Head occupancy once this cycle's pop has been taken into account.
  assign a0  = pop ? v1 : v0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= a0 || res.valid;
      v1 <= (pop ? 1'b0 : v1) || (res.valid && a0);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && !a0) begin
      e0 <= res.item;
    end else if (pop) begin
      e0 <= e1;
    end
    if (res.valid && a0) begin
      e1 <= res.item;
    end
  end

  assign full      = v1;
  assign out_valid = v0;
  assign out_item  = e0;

endmodule

// ===== rtl/annexb_access_unit_splitter.sv =====
// Annex-B access unit splitter: top level with configuration registers and checks.
//
// Usage. Stream bytes enter on the input channel (in_valid, in_stall, stream_byte,
// restart) and leave, cut into access units, on the output channel (out_valid,
// out_stall, unit_byte, unit_last, unit_keyframe, unit_first). An item moves at a
// rising edge of clk where valid is high and stall is low.
// Every byte passes through a lookahead window of LOOKAHEAD_DEPTH bytes, so a byte
// leaves only when LOOKAHEAD_DEPTH later bytes have been accepted; its result item
// then enters the output buffer at the accepting edge. The tail of a stream stays in
// the window until later bytes, for instance of the next stream, push it out.
// Bytes before the first start code produce no item.
// Throughput is one byte per cycle while in_stall is low: the window logic is a single
// registered pass, and a two-entry output buffer lets the block accept a byte while a
// result waits. in_stall rises only when both buffer entries hold items, i.e. after the
// receiver has stalled with a further result arriving; it is driven from a register.
// Reset (rst, synchronous, active high) empties the window and buffer and returns the
// configuration registers to their defaults. A byte with restart set clears the window
// and unit state first (not the registers) and then enters the window. Configuration is
// written through cfg_write, cfg_index and cfg_data by the user while idle (not enforced).
`include "annexb_access_unit_splitter_macros.svh"

module annexb_access_unit_splitter #(
  parameter int LOOKAHEAD_DEPTH = aaus_pkg::LOOKAHEAD_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [aaus_pkg::BYTE_W-1:0]       stream_byte,
  input  logic                              restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [aaus_pkg::BYTE_W-1:0]       unit_byte,
  output logic                              unit_last,
  output logic                              unit_keyframe,
  output logic                              unit_first,
  input  logic                              cfg_write,
  input  logic [aaus_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aaus_pkg::MASK_W-1:0]       cfg_data
);
  import aaus_pkg::*;

  logic [MASK_W-1:0]     attach_type_mask;
  logic [NAL_TYPE_W-1:0] key_nal_type;
  logic                  in_accept;
  logic                  buf_full;
  res_t                  core_res;
  status_t               core_st;
  item_t                 out_item;

  // Configuration registers; an index is one of the two register codes.
  always_ff @(posedge clk) begin
    if (rst) begin
      attach_type_mask <= ATTACH_MASK_RESET;
      key_nal_type     <= KEY_TYPE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_ATTACH_MASK: attach_type_mask <= cfg_data;
        CFG_KEY_TYPE:    key_nal_type     <= cfg_data[NAL_TYPE_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !in_stall;

  aaus_window #(
    .DEPTH(LOOKAHEAD_DEPTH)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .stream_byte (stream_byte),
    .restart     (restart),
    .attach_mask (attach_type_mask),
    .key_type    (key_nal_type),
    .res         (core_res),
    .st          (core_st)
  );

  aaus_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res       (core_res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign unit_byte     = out_item.data;
  assign unit_last     = out_item.last;
  assign unit_keyframe = out_item.keyframe;
  assign unit_first    = out_item.first;

  // The opening byte of a unit is a start code zero and can never close it.
  `AAUS_ASSERT_NOW(a_first_not_last, out_valid && unit_first, !unit_last, "unit opens and closes on one byte")
  // A result is only produced from a full window, never from a restart byte.
  `AAUS_ASSERT_NOW(a_res_needs_full, core_res.valid, core_st.full && !restart && in_accept, "result without full window")
  // After a restart the window refills from a single byte.
  `AAUS_ASSERT_NEXT(a_restart_clears, in_accept && restart, !core_st.full && !core_st.synced, "restart left state behind")

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench of the Annex-B access unit splitter.
`timescale 1ns / 1ps

module tb;
  import aaus_pkg::*;

  localparam int LOOK = LOOKAHEAD_DEPTH_DEF;

  // Watchdog: cycles in which no item moves on either channel before the run is abandoned.
  // The longest quiet stretch of a correct run is the deliberate receiver hold-off.
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 64;
  localparam int PHASE_BYTES = 200;
  localparam int NUM_PHASES = 6;

  // NAL unit types the stream generator favours.
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR = 5'd5;
  localparam logic [4:0] NAL_SEI = 5'd6;
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_AUD = 5'd9;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_UNIT_BYTE,
    ROW_UNIT_BYTE
  } row_kind_e;

  typedef struct {
    logic [7:0] b;
    logic       rs;
    row_kind_e  kind;
    item_t      want;
  } stim_row_t;

  localparam item_t NO_ITEM = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] stream_byte = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [BYTE_W-1:0] unit_byte;
  logic unit_last;
  logic unit_keyframe;
  logic unit_first;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASK_W-1:0] cfg_data = '0;

  always #10 clk = ~clk;

  annexb_access_unit_splitter DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_byte   (stream_byte),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .unit_byte     (unit_byte),
    .unit_last     (unit_last),
    .unit_keyframe (unit_keyframe),
    .unit_first    (unit_first),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------------------
  // Predictor state. It mirrors the block: the lookahead window, the count of
  // start-code bytes and the header byte still to pass before the boundary search
  // resumes, whether a start code has been seen, whether the next byte sent opens a
  // unit, and the keyframe flag of the open unit. The two registers are kept here too.
  // ---------------------------------------------------------------------------------
  logic [7:0]  win [LOOK];
  int unsigned win_fill = 0;
  int unsigned code_left = 0;
  bit          hdr_left = 1'b0;
  bit          locked = 1'b0;
  bit          unit_pending = 1'b1;
  bit          unit_key = 1'b0;
  logic [MASK_W-1:0]     attach_mask = ATTACH_MASK_RESET;
  logic [NAL_TYPE_W-1:0] key_type = KEY_TYPE_RESET;

  // Unit bytes the block still owes, oldest first.
  item_t pending_unit_bytes [$];

  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent = 0;
  int unsigned tx_idle_max = 8;
  int unsigned rx_idle_max = 8;
  bit          long_hold_req = 1'b0;
  bit          long_hold_done = 1'b0;

  initial begin
    for (int i = 0; i < LOOK; i++) win[i] = 8'h00;
  end

  // Length of a start code beginning at window slot p, or zero. A code is only
  // recognised once its NAL header byte is inside the window as well.
  function automatic int unsigned code_len_at(input int unsigned p);
    if (p + 4 < LOOK && win[p] == 8'h00 && win[p+1] == 8'h00 && win[p+2] == 8'h00 &&
        win[p+3] == 8'h01)
      return 4;
    if (p + 3 < LOOK && win[p] == 8'h00 && win[p+1] == 8'h00 && win[p+2] == 8'h01)
      return 3;
    return 0;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < LOOK; i++) win[i] = 8'h00;
    win_fill = 0;
    code_left = 0;
    hdr_left = 1'b0;
    locked = 1'b0;
    unit_pending = 1'b1;
    unit_key = 1'b0;
  endfunction

  // Takes one accepted stream byte and works out the unit byte it pushes out of the
  // window, if any. Returns 1 when a unit byte is due.
  function automatic bit predict_unit_byte(input logic [7:0] b, input logic rs,
                                           output item_t res);
    int unsigned head;
    int unsigned nxt;
    bit got;
    bit last;
    bit first;
    res = NO_ITEM;
    got = 1'b0;
    if (rs) clear_window();
    if (win_fill < LOOK) begin
      win[win_fill] = b;
      win_fill++;
      return 1'b0;
    end
    head = code_len_at(0);
    // Before the first start code the oldest byte simply falls out of the window.
    if (locked || head != 0) begin
      first = 1'b0;
      last = 1'b0;
      if (unit_pending && head != 0) begin
        unit_key = (win[head][4:0] == key_type);
        code_left = head - 1;
        hdr_left = 1'b1;
        unit_pending = 1'b0;
        locked = 1'b1;
        first = 1'b1;
      end
      // No boundary is looked for while a start code or its header byte passes.
      if (code_left > 0) begin
        code_left--;
      end else if (hdr_left) begin
        hdr_left = 1'b0;
      end else begin
        nxt = code_len_at(1);
        if (nxt != 0) begin
          if (attach_mask[win[1+nxt][4:0]]) begin
            code_left = nxt - 1;
            hdr_left = 1'b1;
          end else begin
            last = 1'b1;
            unit_pending = 1'b1;
          end
        end
      end
      res.data = win[0];
      res.last = last;
      res.keyframe = unit_key;
      res.first = first;
      got = 1'b1;
    end
    for (int i = 0; i < LOOK - 1; i++) win[i] = win[i+1];
    win[LOOK-1] = b;
    return got;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------------
  // Sender side. An item is offered after a random gap and held until the block takes
  // it; the byte is then passed through the predictor at the accepting edge.
  // ---------------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input logic rs, output bit got,
                            output item_t res);
    int unsigned gap;
    gap = $urandom_range(tx_idle_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_byte <= b;
    restart <= rs;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    got = predict_unit_byte(b, rs, res);
  endtask

  task automatic send_byte(input logic [7:0] b);
    bit got;
    item_t res;
    // Now and then the stream is restarted in the middle of whatever it carries.
    offer_byte(b, ($urandom_range(79, 0) == 0), got, res);
    if (got) pending_unit_bytes.push_back(res);
  endtask

  function automatic logic [4:0] pick_nal_type();
    case ($urandom_range(7, 0))
      0: return NAL_SLICE;
      1: return NAL_IDR;
      2: return NAL_SEI;
      3: return NAL_SPS;
      4: return NAL_PPS;
      5: return NAL_AUD;
      6: return key_type;
      default: return 5'($urandom_range(31, 0));
    endcase
  endfunction

  // One NAL unit with random content, or once in a while a burst of noise. Payload
  // bytes lean towards zero so that stray and broken start codes turn up as well.
  task automatic send_nal();
    int unsigned extra_zeros;
    int unsigned payload_len;
    logic [7:0] b;
    if ($urandom_range(9, 0) == 0) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom()));
    end else begin
      extra_zeros = ($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0;
      repeat (extra_zeros) send_byte(8'h00);
      if ($urandom_range(1, 0) == 1) send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte({3'($urandom_range(7, 0)), pick_nal_type()});
      payload_len = $urandom_range(10, 0);
      repeat (payload_len) begin
        b = ($urandom_range(7, 0) == 0) ? 8'h00 : 8'($urandom());
        send_byte(b);
      end
    end
  endtask

  // Lowers valid at the accepting edge of the last item, then waits until every
  // owed unit byte has arrived and idles on after that, since the last bytes taken in
  // may cause no result while the block still settles.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_unit_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_ATTACH_MASK) attach_mask = data;
    else key_type = data[NAL_TYPE_W-1:0];
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // Directed stream under the reset configuration. Two junk bytes come first and are
  // dropped, then a unit opened by a 4-byte start code of an IDR slice, an attached
  // SEI behind a 3-byte code, and a plain slice behind a 4-byte code that closes the
  // unit. A run of four zeros before 01 follows, and a restart then clears the window,
  // so neither that run nor the restart byte produces a unit byte. Where the unit byte
  // is easy to follow by hand it is written out; the rest goes to the predictor.
  // ---------------------------------------------------------------------------------
  stim_row_t stim_rows [28] = '{
    '{8'hFF, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h7E, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h00, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h00, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h00, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h01, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'h65, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'hFF, 1'b0, ROW_NO_UNIT_BYTE, NO_ITEM},
    '{8'hAA, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{8'h00, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h01, 1'b0, ROW_UNIT_BYTE, '{8'h01, 1'b0, 1'b1, 1'b0}},
    '{8'h06, 1'b0, ROW_UNIT_BYTE, '{8'h65, 1'b0, 1'b1, 1'b0}},
    '{8'h11, 1'b0, ROW_UNIT_BYTE, '{8'hFF, 1'b0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, ROW_UNIT_BYTE, '{8'hAA, 1'b0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h00, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{8'h01, 1'b0, ROW_UNIT_BYTE, '{8'h01, 1'b0, 1'b1, 1'b0}},
    '{8'h41, 1'b0, ROW_UNIT_BYTE, '{8'h06, 1'b0, 1'b1, 1'b0}},
    '{8'h22, 1'b0, ROW_UNIT_BYTE, '{8'h11, 1'b1, 1'b1, 1'b0}},
    '{8'h33, 1'b0, ROW_UNIT_BYTE, '{8'h00, 1'b0, 1'b0, 1'b1}},
    '{8'h00, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'h00, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'h00, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'h00, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'h01, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'h25, 1'b0, ROW_PREDICT, NO_ITEM},
    '{8'hFF, 1'b1, ROW_NO_UNIT_BYTE, NO_ITEM}
  };

  initial begin : stimulus
    bit got;
    item_t res;
    logic [MASK_W-1:0] mask;
    logic [NAL_TYPE_W-1:0] key;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      offer_byte(stim_rows[r].b, stim_rows[r].rs, got, res);
      case (stim_rows[r].kind)
        ROW_UNIT_BYTE: pending_unit_bytes.push_back(stim_rows[r].want);
        ROW_PREDICT: if (got) pending_unit_bytes.push_back(res);
        default: ;
      endcase
    end
    wait_for_drain();

    // Random phases. Each starts from an idle block with a fresh pair of register
    // values; the extremes come first, then the defaults, then random settings.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          mask = '0;
          key = '0;
          tx_idle_max = 8;
          rx_idle_max = 8;
        end
        1: begin
          mask = '1;
          key = '1;
          tx_idle_max = 0;
          rx_idle_max = 0;
        end
        2: begin
          mask = ATTACH_MASK_RESET;
          key = KEY_TYPE_RESET;
          tx_idle_max = 0;
          rx_idle_max = 8;
        end
        default: begin
          mask = $urandom();
          key = 5'($urandom_range(31, 0));
          tx_idle_max = (ph == 3) ? 8 : $urandom_range(1, 0) * 8;
          rx_idle_max = (ph == 3) ? 0 : 8;
        end
      endcase
      write_reg(CFG_ATTACH_MASK, mask);
      write_reg(CFG_KEY_TYPE, {{(MASK_W-NAL_TYPE_W){1'b0}}, key});
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        // Midway through the back-to-back phase the receiver stops for a long
        // stretch while bytes keep coming, so the output buffer fills and the
        // block has to stall its input.
        if (ph == 1 && !long_hold_done && bytes_sent >= PHASE_BYTES / 2) begin
          long_hold_req = 1'b1;
          long_hold_done = 1'b1;
        end
        send_nal();
      end
      wait_for_drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[annexb_access_unit_splitter] OK");
    end else begin
      $display("[annexb_access_unit_splitter] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Receiver side. Stall is held for a random number of cycles before each unit byte
  // and dropped until one is taken; on request it is held for one long stretch.
  // ---------------------------------------------------------------------------------
  initial begin : receiver
    int unsigned gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      gap = $urandom_range(rx_idle_max, 0);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Every unit byte taken is compared field by field with the oldest one owed. The
  // same block counts quiet cycles and gives up when the block stops moving.
  always @(posedge clk) begin
    item_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_unit_bytes.size() == 0) begin
          report_mismatch($sformatf("unit byte %h arrived with none owed", unit_byte));
        end else begin
          want = pending_unit_bytes.pop_front();
          if (unit_byte !== want.data)
            report_mismatch($sformatf("unit_byte %h, want %h", unit_byte, want.data));
          if (unit_last !== want.last)
            report_mismatch($sformatf("unit_last %b, want %b", unit_last, want.last));
          if (unit_keyframe !== want.keyframe)
            report_mismatch($sformatf("unit_keyframe %b, want %b", unit_keyframe,
                                      want.keyframe));
          if (unit_first !== want.first)
            report_mismatch($sformatf("unit_first %b, want %b", unit_first, want.first));
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[annexb_access_unit_splitter] ERROR");
        $finish;
      end
    end
  end

endmodule
